[rtl/core/xts_pkg.sv]
package xts_pkg;

	// Register indexes of the configuration port.
	localparam logic [2:0] REG_DKEY_LO = 3'd0;
	localparam logic [2:0] REG_DKEY_HI = 3'd1;
	localparam logic [2:0] REG_TKEY_LO = 3'd2;
	localparam logic [2:0] REG_TKEY_HI = 3'd3;
	localparam logic [2:0] REG_DECRYPT = 3'd4;
	localparam logic [2:0] REG_SECTOR  = 3'd5;

	localparam int MAX_SECTOR_BLOCKS = 1024;
	localparam int NUM_ROUNDS        = 10;

	typedef logic [255:0][7:0] sbox_tbl_t;

	// Round key read request from the sequencer to the key store.
	typedef struct packed {
		logic       sel_tk;
		logic [3:0] idx;
	} kx_rd_t;

	localparam logic [7:0] SBOX [256] = '{
	8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
	8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
	8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
	8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
	8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
	8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
	8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
	8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
	8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
	8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
	8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
	8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
	8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
	8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
	8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
	8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

	// The inverse table is built from the forward table at elaboration.
	function automatic sbox_tbl_t build_inv_sbox();
		sbox_tbl_t t;
		t = '0;
		for (int i = 0; i < 256; i++) begin
			t[SBOX[i]] = i[7:0];
		end
		return t;
	endfunction

	localparam sbox_tbl_t INV_SBOX = build_inv_sbox();

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

endpackage

[rtl/core/aes128_xts_sector_cipher_core.sv]
// A plain word is loaded, passes through the rounds of the shared AES round unit
// and is output once the output is free; the next word is taken only when the
// block is back in idle, so it works on one word at a time. A start word first
// runs the restoring divider, then the tweak cipher and one tweak doubling per
// block skipped within the sector; a sector end adds a tweak cipher pass.
// Reset is asynchronous; after it and each key write the schedule rebuild stalls input.
module aes128_xts_sector_cipher_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        start_req,
	input  logic [63:0] sector_low,
	input  logic [63:0] sector_high,
	input  logic [31:0] skip_blocks,
	input  logic [63:0] block_low,
	input  logic [63:0] block_high,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] result_low,
	output logic [63:0] result_high
);
	import xts_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_LOAD = 3'd2;
	localparam logic [2:0] ST_RND  = 3'd3;
	localparam logic [2:0] ST_DBL  = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;

	logic [63:0]  dkey_lo_q, dkey_hi_q, tkey_lo_q, tkey_hi_q;
	logic         decrypt_q;
	logic [10:0]  sector_blocks_q;
	logic [2:0]   state_q;
	logic         twk_q;
	logic         from_start_q;
	logic [3:0]   rnd_q;
	logic [4:0]   div_cnt_q;
	logic [31:0]  div_q;
	logic [9:0]   rem_q;
	logic [9:0]   dbl_cnt_q;
	logic [9:0]   bis_q;
	logic [127:0] sector_q;
	logic [127:0] tweak_q;
	logic [127:0] blk_q;
	logic [127:0] st_q;
	logic         out_valid_q;
	logic [127:0] result_q;

	logic         cfg_wr;
	logic         kbusy;
	kx_rd_t       kx_rd;
	logic [127:0] rk;
	logic [127:0] round_out;
	logic         dec_eff;
	logic [10:0]  size;
	logic [10:0]  trial;
	logic         trial_ge;
	logic [9:0]   rem_next;
	logic [31:0]  div_next;
	logic [127:0] tweak_dbl;
	logic [10:0]  bis_inc;
	logic         out_free;

	assign cfg_ready = !kbusy;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign in_stall  = (state_q != ST_IDLE) || kbusy;
	assign out_valid = out_valid_q;
	assign result_low  = result_q[63:0];
	assign result_high = result_q[127:64];
	assign dec_eff   = !twk_q && decrypt_q;
	assign out_free  = !out_valid_q || !out_stall;

	// Effective sector size, clamped to 1 .. MAX_SECTOR_BLOCKS.
	always_comb begin
		if (sector_blocks_q == 11'd0) size = 11'd1;
		else if (sector_blocks_q > 11'(MAX_SECTOR_BLOCKS)) size = 11'(MAX_SECTOR_BLOCKS);
		else size = sector_blocks_q;
	end

	// Restoring divider step, one quotient bit per cycle.
	assign trial    = {rem_q, div_q[31]};
	assign trial_ge = trial >= size;
	assign rem_next = trial_ge ? 10'(trial - size) : trial[9:0];
	assign div_next = {div_q[30:0], trial_ge};

	// Tweak doubling in GF(2^128) and the position after this block.
	assign tweak_dbl = {tweak_q[126:0], 1'b0} ^ (tweak_q[127] ? 128'h87 : 128'h0);
	assign bis_inc   = {1'b0, bis_q} + 11'd1;

	// Round key selection for the load and round cycles.
	always_comb begin
		kx_rd.sel_tk = twk_q;
		if (state_q == ST_LOAD) kx_rd.idx = dec_eff ? 4'(NUM_ROUNDS) : 4'd0;
		else kx_rd.idx = dec_eff ? 4'(NUM_ROUNDS) - rnd_q : rnd_q;
	end

	xts_keyexp u_keyexp (
		.clk     (clk),
		.arst_n  (arst_n),
		.dkey    ({dkey_hi_q, dkey_lo_q}),
		.tkey    ({tkey_hi_q, tkey_lo_q}),
		.dk_load (cfg_wr && (cfg_index == REG_DKEY_LO || cfg_index == REG_DKEY_HI)),
		.tk_load (cfg_wr && (cfg_index == REG_TKEY_LO || cfg_index == REG_TKEY_HI)),
		.rd      (kx_rd),
		.rk      (rk),
		.busy    (kbusy)
	);

	xts_round u_round (
		.state_in  (st_q),
		.round_key (rk),
		.dec       (dec_eff),
		.last      (rnd_q == 4'(NUM_ROUNDS)),
		.state_out (round_out)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dkey_lo_q       <= '0;
			dkey_hi_q       <= '0;
			tkey_lo_q       <= '0;
			tkey_hi_q       <= '0;
			decrypt_q       <= 1'b1;
			sector_blocks_q <= 11'd32;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_DKEY_LO: dkey_lo_q <= cfg_data;
				REG_DKEY_HI: dkey_hi_q <= cfg_data;
				REG_TKEY_LO: tkey_lo_q <= cfg_data;
				REG_TKEY_HI: tkey_hi_q <= cfg_data;
				REG_DECRYPT: decrypt_q <= cfg_data[0];
				REG_SECTOR:  sector_blocks_q <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	// Sequencer: divide, tweak cipher, doubling, data cipher, output, and a new tweak cipher at a sector end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			twk_q        <= 1'b0;
			from_start_q <= 1'b0;
			rnd_q        <= '0;
			div_cnt_q    <= '0;
			dbl_cnt_q    <= '0;
			bis_q        <= '0;
			sector_q     <= '0;
			tweak_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != ST_FIN) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && !in_stall) begin
						if (start_req) begin
							sector_q     <= {sector_high, sector_low};
							div_cnt_q    <= '0;
							from_start_q <= 1'b1;
							state_q      <= ST_DIV;
						end else begin
							twk_q   <= 1'b0;
							state_q <= ST_LOAD;
						end
					end
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + 5'd1;
					if (div_cnt_q == 5'd31) begin
						sector_q  <= sector_q + {96'd0, div_next};
						bis_q     <= rem_next;
						dbl_cnt_q <= rem_next;
						twk_q     <= 1'b1;
						state_q   <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					rnd_q   <= 4'd1;
					state_q <= ST_RND;
				end
				ST_RND: begin
					rnd_q <= rnd_q + 4'd1;
					if (rnd_q == 4'(NUM_ROUNDS)) begin
						if (!twk_q) begin
							state_q <= ST_FIN;
						end else begin
							tweak_q <= round_out;
							state_q <= from_start_q ? ST_DBL : ST_IDLE;
						end
					end
				end
				ST_DBL: begin
					if (dbl_cnt_q == 10'd0) begin
						from_start_q <= 1'b0;
						twk_q        <= 1'b0;
						state_q      <= ST_LOAD;
					end else begin
						tweak_q   <= tweak_dbl;
						dbl_cnt_q <= dbl_cnt_q - 10'd1;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						tweak_q     <= tweak_dbl;
						if (bis_inc >= size) begin
							bis_q        <= '0;
							sector_q     <= sector_q + 128'd1;
							twk_q        <= 1'b1;
							from_start_q <= 1'b0;
							state_q      <= ST_LOAD;
						end else begin
							bis_q   <= bis_inc[9:0];
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers: block, cipher state, divider and result.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid && !in_stall) begin
			blk_q <= {block_high, block_low};
			div_q <= skip_blocks;
			rem_q <= '0;
		end
		if (state_q == ST_DIV) begin
			div_q <= div_next;
			rem_q <= rem_next;
		end
		if (state_q == ST_LOAD) begin
			if (twk_q) begin
				// Sector number laid out big-endian: its top byte is byte 0.
				st_q <= {<<8{sector_q}} ^ rk;
			end else begin
				st_q <= blk_q ^ tweak_q ^ rk;
			end
		end
		if (state_q == ST_RND) st_q <= round_out;
		if (state_q == ST_FIN && out_free) result_q <= st_q ^ tweak_q;
	end

endmodule

[rtl/core/xts_round.sv]
module xts_round (
	input  logic [127:0] state_in,
	input  logic [127:0] round_key,
	input  logic         dec,
	input  logic         last,
	output logic [127:0] state_out
);
	import xts_pkg::*;

	logic [7:0]   s   [16];
	logic [7:0]   te  [16];
	logic [7:0]   me  [16];
	logic [7:0]   td  [16];
	logic [7:0]   md  [16];
	logic [127:0] enc_v;
	logic [127:0] dec_v;

	// Byte view of the state, byte 0 in the low bits.
	always_comb begin
		for (int i = 0; i < 16; i++) begin
			s[i] = state_in[8*i +: 8];
		end
	end

	// Forward round: SubBytes, ShiftRows, MixColumns unless last, then key.
	always_comb begin
		logic [7:0] a0, a1, a2, a3;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				te[r + 4*c] = SBOX[s[r + 4*((c + r) % 4)]];
			end
		end
		for (int c = 0; c < 4; c++) begin
			a0 = te[4*c];
			a1 = te[4*c+1];
			a2 = te[4*c+2];
			a3 = te[4*c+3];
			me[4*c]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
			me[4*c+1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
			me[4*c+2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
			me[4*c+3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
		end
		for (int i = 0; i < 16; i++) begin
			enc_v[8*i +: 8] = (last ? te[i] : me[i]) ^ round_key[8*i +: 8];
		end
	end

	// Inverse round: InvShiftRows, InvSubBytes, key, InvMixColumns unless last.
	always_comb begin
		logic [7:0] a [4];
		logic [7:0] x2 [4];
		logic [7:0] x4 [4];
		logic [7:0] x8 [4];
		logic [7:0] m9 [4];
		logic [7:0] mb [4];
		logic [7:0] md_ [4];
		logic [7:0] me_ [4];
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				td[r + 4*c] = INV_SBOX[s[r + 4*((c + 4 - r) % 4)]]
					^ round_key[8*(r + 4*c) +: 8];
			end
		end
		for (int c = 0; c < 4; c++) begin
			for (int j = 0; j < 4; j++) begin
				a[j]   = td[4*c + j];
				x2[j]  = xtime(a[j]);
				x4[j]  = xtime(x2[j]);
				x8[j]  = xtime(x4[j]);
				m9[j]  = x8[j] ^ a[j];
				mb[j]  = x8[j] ^ x2[j] ^ a[j];
				md_[j] = x8[j] ^ x4[j] ^ a[j];
				me_[j] = x8[j] ^ x4[j] ^ x2[j];
			end
			md[4*c]   = me_[0] ^ mb[1] ^ md_[2] ^ m9[3];
			md[4*c+1] = m9[0] ^ me_[1] ^ mb[2] ^ md_[3];
			md[4*c+2] = md_[0] ^ m9[1] ^ me_[2] ^ mb[3];
			md[4*c+3] = mb[0] ^ md_[1] ^ m9[2] ^ me_[3];
		end
		for (int i = 0; i < 16; i++) begin
			dec_v[8*i +: 8] = last ? td[i] : md[i];
		end
	end

	assign state_out = dec ? dec_v : enc_v;

endmodule

[rtl/core/xts_keyexp.sv]
module xts_keyexp (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [127:0]   dkey,
	input  logic [127:0]   tkey,
	input  logic           dk_load,
	input  logic           tk_load,
	input  xts_pkg::kx_rd_t rd,
	output logic [127:0]   rk,
	output logic           busy
);
	import xts_pkg::*;

	logic [127:0] dk_rk_q [11];
	logic [127:0] tk_rk_q [11];
	logic         pend_dk_q;
	logic         pend_tk_q;
	logic         run_q;
	logic         sel_tk_q;
	logic [3:0]   cnt_q;
	logic [7:0]   rcon_q;
	logic [127:0] kx_q;
	logic [127:0] kx_next;
	logic [127:0] key_first;
	logic         start;
	logic         start_tk;

	assign busy     = run_q | pend_dk_q | pend_tk_q;
	assign start    = !run_q && (pend_dk_q || pend_tk_q);
	assign start_tk = !pend_dk_q;
	assign key_first = start_tk ? tkey : dkey;
	assign rk = rd.sel_tk ? tk_rk_q[rd.idx] : dk_rk_q[rd.idx];

	// One key expansion step: rotate, substitute and chain the four words.
	always_comb begin
		logic [31:0] t, n0, n1, n2, n3;
		t  = {SBOX[kx_q[103:96]], SBOX[kx_q[127:120]],
		      SBOX[kx_q[119:112]], SBOX[kx_q[111:104]] ^ rcon_q};
		n0 = kx_q[31:0] ^ t;
		n1 = kx_q[63:32] ^ n0;
		n2 = kx_q[95:64] ^ n1;
		n3 = kx_q[127:96] ^ n2;
		kx_next = {n3, n2, n1, n0};
	end

	// Sequencer: reset and every key write schedule an expansion.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_dk_q <= 1'b1;
			pend_tk_q <= 1'b1;
			run_q     <= 1'b0;
			sel_tk_q  <= 1'b0;
			cnt_q     <= '0;
		end else begin
			if (start) begin
				run_q    <= 1'b1;
				sel_tk_q <= start_tk;
				cnt_q    <= 4'd1;
				if (start_tk) pend_tk_q <= 1'b0;
				else pend_dk_q <= 1'b0;
			end else if (run_q) begin
				if (cnt_q == 4'(NUM_ROUNDS)) run_q <= 1'b0;
				cnt_q <= cnt_q + 4'd1;
			end
			if (dk_load) pend_dk_q <= 1'b1;
			if (tk_load) pend_tk_q <= 1'b1;
		end
	end

	// Round key storage, one entry written per cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			kx_q   <= key_first;
			rcon_q <= 8'h01;
			if (start_tk) tk_rk_q[0] <= key_first;
			else dk_rk_q[0] <= key_first;
		end else if (run_q) begin
			kx_q   <= kx_next;
			rcon_q <= xtime(rcon_q);
			if (sel_tk_q) tk_rk_q[cnt_q] <= kx_next;
			else dk_rk_q[cnt_q] <= kx_next;
		end
	end

endmodule

[rtl/core/xts_checker.sv]
module xts_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [2:0]  cfg_index,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] result_low,
	input logic [63:0] result_high
);
	import xts_pkg::*;

	// A held result word stays valid.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result word dropped while stalled");

	// A held result word keeps its value.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(result_low) && $stable(result_high))
		else $error("result word changed while stalled");

	// Every input word keeps the block busy, so the input stalls right after it is taken.
	a_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken in back-to-back cycles");

	// A key write starts a schedule rebuild, which holds off input words.
	a_key_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready && (cfg_index == REG_DKEY_LO || cfg_index == REG_DKEY_HI
		|| cfg_index == REG_TKEY_LO || cfg_index == REG_TKEY_HI) |=> in_stall && !cfg_ready)
		else $error("key schedule not rebuilt after key write");

endmodule

bind aes128_xts_sector_cipher_core xts_checker u_xts_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cfg_valid   (cfg_valid),
	.cfg_ready   (cfg_ready),
	.cfg_index   (cfg_index),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.result_low  (result_low),
	.result_high (result_high)
);

[test/aes128_xts_sector_cipher_core_test.sv]
module aes128_xts_sector_cipher_core_test;
	import xts_pkg::*;

	// Writes to these indexes must be ignored by the block.
	localparam logic [2:0] REG_UNUSED_LO = 3'd6;
	localparam logic [2:0] REG_UNUSED_HI = 3'd7;
	localparam int CYCLE_LIMIT = 800000;
	localparam int PHASES = 10;
	localparam int WORDS_PER_PHASE = 95;

	typedef struct {
		bit           start;
		logic [127:0] sector;
		logic [31:0]  skip;
		logic [127:0] blk;
		bit           typed;
		logic [127:0] want;
	} xts_word_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic        start_req;
	logic [63:0] sector_low;
	logic [63:0] sector_high;
	logic [31:0] skip_blocks;
	logic [63:0] block_low;
	logic [63:0] block_high;
	logic        out_valid;
	logic        out_stall;
	logic [63:0] result_low;
	logic [63:0] result_high;

	aes128_xts_sector_cipher_core dut (.*);

	// Shadow copy of the block's configuration and running state.
	logic [127:0] data_key, tweak_key;
	logic         decrypt_on;
	logic [10:0]  blocks_per_sector;
	logic [127:0] cur_sector, cur_tweak;
	int           pos_in_sector;
	logic [127:0] rk_data [11];
	logic [127:0] rk_tweak [11];
	logic [7:0]   fwd_sub [256];
	logic [7:0]   rev_sub [256];

	logic [127:0] results_due [$];
	int           mismatches;
	int           cycles;
	bit           calm;
	bit           hold_req;

	// Directed words; the first one is the standard AES-128 example with a zero tweak.
	xts_word_t directed [11] = '{
		'{1'b0, 128'h0, 32'h0, 128'hffeeddccbbaa99887766554433221100,
			1'b1, 128'h5ac5b47080b7cdd830047b6ad8e0c469},
		'{1'b0, 128'h0, 32'h0, 128'h0, 1'b0, 128'h0},
		'{1'b1, 128'h0, 32'h0, ~128'h0, 1'b0, 128'h0},
		'{1'b1, ~128'h0, 32'h0, 128'h0123456789abcdef0f1e2d3c4b5a6978, 1'b0, 128'h0},
		'{1'b1, ~128'h0, 32'd31, 128'h55, 1'b0, 128'h0},
		'{1'b0, 128'h0, 32'h0, 128'haaaa5555aaaa5555aaaa5555aaaa5555, 1'b0, 128'h0},
		'{1'b1, {64'h0, ~64'h0}, 32'd32, 128'h0, 1'b0, 128'h0},
		'{1'b1, 128'h0, 32'hffffffff, ~128'h0, 1'b0, 128'h0},
		'{1'b0, 128'h0, 32'h0, 128'h1, 1'b0, 128'h0},
		'{1'b1, 128'd5, 32'h0, 128'h1, 1'b0, 128'h0},
		'{1'b0, 128'h0, 32'h0, 128'h80000000000000000000000000000000, 1'b0, 128'h0}
	};

	function automatic logic [7:0] xt8(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] r;
		r = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) r ^= a;
			a = xt8(a);
		end
		return r;
	endfunction

	function automatic logic [7:0] rol8(input logic [7:0] b, input int n);
		return (b << n) | (b >> (8 - n));
	endfunction

	// S-box from the field inverse and the affine map.
	function automatic void build_sub_tables();
		logic [7:0] inv, x;
		for (int i = 0; i < 256; i++) begin
			inv = 8'h01;
			for (int k = 0; k < 254; k++) inv = gf_mul(inv, i[7:0]);
			x = inv ^ rol8(inv, 1) ^ rol8(inv, 2) ^ rol8(inv, 3) ^ rol8(inv, 4) ^ 8'h63;
			fwd_sub[i] = x;
			rev_sub[x] = i[7:0];
		end
	endfunction

	function automatic void key_sched(input logic [127:0] k, input bit tweak_side);
		logic [31:0] w [44];
		logic [31:0] t;
		logic [7:0]  rcon;
		rcon = 8'h01;
		for (int i = 0; i < 4; i++) w[i] = k[32*i +: 32];
		for (int i = 4; i < 44; i++) begin
			t = w[i-1];
			if (i % 4 == 0) begin
				t = {fwd_sub[t[7:0]], fwd_sub[t[31:24]], fwd_sub[t[23:16]],
					fwd_sub[t[15:8]] ^ rcon};
				rcon = xt8(rcon);
			end
			w[i] = w[i-4] ^ t;
		end
		for (int r = 0; r < 11; r++) begin
			if (tweak_side) rk_tweak[r] = {w[4*r+3], w[4*r+2], w[4*r+1], w[4*r]};
			else rk_data[r] = {w[4*r+3], w[4*r+2], w[4*r+1], w[4*r]};
		end
	endfunction

	function automatic logic [127:0] cipher_fwd(input logic [127:0] din, input bit tweak_side);
		logic [127:0] s, t;
		logic [7:0]   a0, a1, a2, a3;
		s = din ^ (tweak_side ? rk_tweak[0] : rk_data[0]);
		for (int rnd = 1; rnd <= 10; rnd++) begin
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 4; r++)
					t[8*(r+4*c) +: 8] = fwd_sub[s[8*(r+4*((c+r)%4)) +: 8]];
			if (rnd < 10) begin
				for (int c = 0; c < 4; c++) begin
					a0 = t[32*c +: 8]; a1 = t[32*c+8 +: 8];
					a2 = t[32*c+16 +: 8]; a3 = t[32*c+24 +: 8];
					s[32*c +: 8]    = xt8(a0) ^ xt8(a1) ^ a1 ^ a2 ^ a3;
					s[32*c+8 +: 8]  = a0 ^ xt8(a1) ^ xt8(a2) ^ a2 ^ a3;
					s[32*c+16 +: 8] = a0 ^ a1 ^ xt8(a2) ^ xt8(a3) ^ a3;
					s[32*c+24 +: 8] = xt8(a0) ^ a0 ^ a1 ^ a2 ^ xt8(a3);
				end
			end else begin
				s = t;
			end
			s ^= tweak_side ? rk_tweak[rnd] : rk_data[rnd];
		end
		return s;
	endfunction

	function automatic logic [127:0] cipher_inv(input logic [127:0] din);
		logic [127:0] s, t;
		logic [7:0]   a0, a1, a2, a3;
		s = din ^ rk_data[10];
		for (int rnd = 10; rnd >= 1; rnd--) begin
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 4; r++)
					t[8*(r+4*((c+r)%4)) +: 8] = rev_sub[s[8*(r+4*c) +: 8]];
			s = t ^ rk_data[rnd-1];
			if (rnd > 1) begin
				for (int c = 0; c < 4; c++) begin
					a0 = s[32*c +: 8]; a1 = s[32*c+8 +: 8];
					a2 = s[32*c+16 +: 8]; a3 = s[32*c+24 +: 8];
					s[32*c +: 8]    = gf_mul(a0, 8'd14) ^ gf_mul(a1, 8'd11)
						^ gf_mul(a2, 8'd13) ^ gf_mul(a3, 8'd9);
					s[32*c+8 +: 8]  = gf_mul(a0, 8'd9) ^ gf_mul(a1, 8'd14)
						^ gf_mul(a2, 8'd11) ^ gf_mul(a3, 8'd13);
					s[32*c+16 +: 8] = gf_mul(a0, 8'd13) ^ gf_mul(a1, 8'd9)
						^ gf_mul(a2, 8'd14) ^ gf_mul(a3, 8'd11);
					s[32*c+24 +: 8] = gf_mul(a0, 8'd11) ^ gf_mul(a1, 8'd13)
						^ gf_mul(a2, 8'd9) ^ gf_mul(a3, 8'd14);
				end
			end
		end
		return s;
	endfunction

	function automatic int eff_sector_size();
		if (blocks_per_sector == 0) return 1;
		if (blocks_per_sector > MAX_SECTOR_BLOCKS) return MAX_SECTOR_BLOCKS;
		return int'(blocks_per_sector);
	endfunction

	function automatic void tweak_double();
		cur_tweak = {cur_tweak[126:0], 1'b0} ^ (cur_tweak[127] ? 128'h87 : 128'h0);
	endfunction

	// The sector number enters the tweak cipher most significant byte first.
	function automatic void tweak_fresh();
		logic [127:0] b;
		for (int i = 0; i < 16; i++) b[8*i +: 8] = cur_sector[8*(15-i) +: 8];
		cur_tweak = cipher_fwd(b, 1'b1);
	endfunction

	function automatic logic [127:0] xts_transform(input xts_word_t w);
		int           size, rem;
		logic [127:0] r;
		size = eff_sector_size();
		if (w.start) begin
			cur_sector = w.sector + 128'(w.skip / size);
			rem = int'(w.skip % size);
			tweak_fresh();
			for (int i = 0; i < rem; i++) tweak_double();
			pos_in_sector = rem;
		end
		r = decrypt_on ? cipher_inv(w.blk ^ cur_tweak) : cipher_fwd(w.blk ^ cur_tweak, 1'b0);
		r ^= cur_tweak;
		tweak_double();
		pos_in_sector++;
		if (pos_in_sector >= size) begin
			pos_in_sector = 0;
			cur_sector += 128'd1;
			tweak_fresh();
		end
		return r;
	endfunction

	function automatic void shadow_write(input logic [2:0] idx, input logic [63:0] val);
		case (idx)
			REG_DKEY_LO: begin data_key[63:0] = val; key_sched(data_key, 1'b0); end
			REG_DKEY_HI: begin data_key[127:64] = val; key_sched(data_key, 1'b0); end
			REG_TKEY_LO: begin tweak_key[63:0] = val; key_sched(tweak_key, 1'b1); end
			REG_TKEY_HI: begin tweak_key[127:64] = val; key_sched(tweak_key, 1'b1); end
			REG_DECRYPT: decrypt_on = val[0];
			REG_SECTOR:  blocks_per_sector = val[10:0];
			default: ;
		endcase
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Mostly small skips so that the tweak doubling stays short.
	function automatic xts_word_t rand_word();
		xts_word_t w;
		int size;
		size = eff_sector_size();
		w.start = ($urandom_range(0, 9) == 0);
		case ($urandom_range(0, 3))
			0: w.sector = {96'h0, $urandom};
			1: w.sector = ~128'h0 - 128'($urandom_range(0, 3));
			2: w.sector = {64'h0, ~64'h0 - 64'($urandom_range(0, 3))};
			default: w.sector = {rand64(), rand64()};
		endcase
		w.skip = ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 3 * size + 2);
		w.blk = {rand64(), rand64()};
		w.typed = 1'b0;
		w.want = 128'h0;
		return w;
	endfunction

	// Clock and cycle limit.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Result stall: random bursts, plus one long hold on request.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (400) @(posedge clk);
				hold_req = 1'b0;
				out_stall <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Compare every accepted result word with the oldest prediction.
	always @(posedge clk) begin
		logic [127:0] due;
		if (arst_n && out_valid && !out_stall) begin
			if (results_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result word %h %h", result_high, result_low);
			end else begin
				due = results_due.pop_front();
				if (result_low !== due[63:0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result_low: expected %h, got %h", due[63:0], result_low);
				end
				if (result_high !== due[127:64]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result_high: expected %h, got %h", due[127:64], result_high);
				end
			end
		end
	end

	// Offer one word and hold it until the block takes it.
	task automatic put_word(input xts_word_t w);
		logic [127:0] r;
		in_valid <= 1'b1;
		start_req <= w.start;
		sector_low <= w.sector[63:0];
		sector_high <= w.sector[127:64];
		skip_blocks <= w.skip;
		block_low <= w.blk[63:0];
		block_high <= w.blk[127:64];
		do @(posedge clk); while (in_stall);
		r = xts_transform(w);
		results_due.push_back(w.typed ? w.want : r);
	endtask

	task automatic feed(input xts_word_t w);
		put_word(w);
		if (!calm && !hold_req && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		shadow_write(idx, val);
	endtask

	// Let every outstanding word drain, then allow for a trailing tweak or key pass.
	task automatic drain();
		in_valid <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	initial begin
		int sizes [PHASES] = '{1, 0, 1024, 2047, 2, 3, 1025, 17, 5, 32};
		cfg_valid = 1'b0; cfg_index = REG_DKEY_LO; cfg_data = '0;
		in_valid = 1'b0; start_req = 1'b0; sector_low = '0; sector_high = '0;
		skip_blocks = '0; block_low = '0; block_high = '0;
		mismatches = 0; cycles = 0; calm = 1'b0; hold_req = 1'b0;
		arst_n = 1'b0;
		build_sub_tables();
		data_key = '0; tweak_key = '0; decrypt_on = 1'b1; blocks_per_sector = 11'd32;
		cur_sector = '0; cur_tweak = '0; pos_in_sector = 0;
		key_sched(data_key, 1'b0);
		key_sched(tweak_key, 1'b1);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: standard key, encryption, default sector size.
		write_reg(REG_DKEY_LO, 64'h0706050403020100);
		write_reg(REG_DKEY_HI, 64'h0f0e0d0c0b0a0908);
		write_reg(REG_DECRYPT, 64'h0);
		cfg_valid <= 1'b0;
		foreach (directed[i]) feed(directed[i]);
		drain();

		// Random phases, each with its own settings.
		for (int p = 0; p < PHASES; p++) begin
			write_reg(REG_SECTOR, 64'(sizes[p]));
			write_reg(REG_DECRYPT, (p == 3) ? ~64'h0 : 64'(p % 2));
			if (p == 5) begin
				write_reg(REG_DKEY_LO, ~64'h0);
				write_reg(REG_DKEY_HI, ~64'h0);
				write_reg(REG_TKEY_LO, ~64'h0);
				write_reg(REG_TKEY_HI, ~64'h0);
			end else if (p == 6) begin
				write_reg(REG_TKEY_LO, 64'h0);
				write_reg(REG_TKEY_HI, 64'h0);
				write_reg(REG_UNUSED_LO, rand64());
				write_reg(REG_UNUSED_HI, rand64());
			end else if (p % 2 == 0) begin
				write_reg(REG_DKEY_LO, rand64());
				write_reg(REG_DKEY_HI, rand64());
				write_reg(REG_TKEY_LO, rand64());
				write_reg(REG_TKEY_HI, rand64());
			end
			cfg_valid <= 1'b0;
			calm = (p == PHASES - 1);
			for (int n = 0; n < WORDS_PER_PHASE; n++) begin
				if (p == 4 && n == 10) hold_req = 1'b1;
				feed(rand_word());
			end
			drain();
		end

		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
